/* src/int8_quantized_add_requantize_macros.svh */
`ifndef INT8_QUANTIZED_ADD_REQUANTIZE_MACROS_SVH
`define INT8_QUANTIZED_ADD_REQUANTIZE_MACROS_SVH

// same-cycle implication
`define IQAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define IQAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/iqar_pkg.sv */
`timescale 1ns / 1ps

package iqar_pkg;

  localparam int unsigned FracBitsDef = 24;
  localparam int unsigned MaskPack    = 8;
  localparam int unsigned PosW        = $clog2(MaskPack);
  localparam int unsigned ProdW       = 40;
  localparam int unsigned AccW        = 42;
  localparam int unsigned BiasW       = 40;
  localparam int unsigned CfgW        = 40;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_FLAG = 2'd1,
    MODE_PACK = 2'd2
  } mask_mode_e;

  typedef enum logic [1:0] {
    CFG_SCALE_A = 2'd0,
    CFG_SCALE_B = 2'd1,
    CFG_BIAS    = 2'd2,
    CFG_MODE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic signed [ProdW-1:0] prod_a;
    logic signed [ProdW-1:0] prod_b;
  } prod_beat_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] sum;
  } rq_res_t;

  typedef struct packed {
    logic       adv;
    logic       last;
    logic       ok;
    logic [1:0] mode;
  } pack_ctl_t;

endpackage

/* src/iqar_front.sv */
`timescale 1ns / 1ps

module iqar_front import iqar_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         elem_a_i,
  input  logic [7:0]         elem_b_i,
  input  logic               last_i,
  input  logic [31:0]        scale_a_i,
  input  logic [31:0]        scale_b_i,
  input  logic               down_ready_i,
  output prod_beat_t         prod_o
);

  logic       a_valid_q;
  logic       a_last_q;
  logic [7:0] a_elem_a_q;
  logic [7:0] a_elem_b_q;

  logic                    b_valid_q;
  logic                    b_last_q;
  logic signed [ProdW-1:0] b_prod_a_q, b_prod_a_d;
  logic signed [ProdW-1:0] b_prod_b_q, b_prod_b_d;

  logic b_free, a_free, a_move;

  assign b_free     = !b_valid_q || down_ready_i;
  assign a_move     = a_valid_q && b_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_ready_o = a_free;

  assign b_prod_a_d = $signed({{32{a_elem_a_q[7]}}, a_elem_a_q})
                    * $signed({{8{scale_a_i[31]}}, scale_a_i});
  assign b_prod_b_d = $signed({{32{a_elem_b_q[7]}}, a_elem_b_q})
                    * $signed({{8{scale_b_i[31]}}, scale_b_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= in_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_free) begin
      a_elem_a_q <= elem_a_i;
      a_elem_b_q <= elem_b_i;
      a_last_q   <= last_i;
    end
    if (a_move) begin
      b_prod_a_q <= b_prod_a_d;
      b_prod_b_q <= b_prod_b_d;
      b_last_q   <= a_last_q;
    end
  end

  assign prod_o.valid  = b_valid_q;
  assign prod_o.last   = b_last_q;
  assign prod_o.prod_a = b_prod_a_q;
  assign prod_o.prod_b = b_prod_b_q;

endmodule

/* src/iqar_requant.sv */
`timescale 1ns / 1ps

module iqar_requant import iqar_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic signed [ProdW-1:0] prod_a_i,
  input  logic signed [ProdW-1:0] prod_b_i,
  input  logic [BiasW-1:0]        bias_i,
  output rq_res_t                 res_o
);

  localparam logic [AccW:0] Half = (AccW+1)'(1) << (FRAC_BITS - 1);

  logic signed [AccW-1:0] acc;
  logic                   neg;
  logic [AccW-1:0]        mag;
  logic [AccW:0]          rnd;
  logic [AccW:0]          q;

  assign acc = AccW'(prod_a_i) + AccW'(prod_b_i) + AccW'($signed(bias_i));
  assign neg = acc[AccW-1];
  assign mag = neg ? AccW'(-acc) : AccW'(acc);
  assign rnd = {1'b0, mag} + Half;
  assign q   = rnd >> FRAC_BITS;

  always_comb begin
    res_o.ok  = 1'b1;
    res_o.sum = 8'(q);
    if (neg) begin
      if (q > (AccW+1)'(128)) begin
        res_o.sum = 8'h80;
        res_o.ok  = 1'b0;
      end else begin
        res_o.sum = 8'(-q);
      end
    end else if (q > (AccW+1)'(127)) begin
      res_o.sum = 8'h7f;
      res_o.ok  = 1'b0;
    end
  end

endmodule

/* src/iqar_mask_pack.sv */
`timescale 1ns / 1ps

module iqar_mask_pack import iqar_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pack_ctl_t ctl_i,
  output logic [MaskPack-1:0] mask_byte_o,
  output logic      mask_valid_o
);

  logic [MaskPack-1:0] bits_q, bits_d, bits_upd, sel;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                active, emit;

  assign active   = ctl_i.mode == MODE_PACK;
  assign sel      = MaskPack'(1) << pos_q;
  assign bits_upd = ctl_i.ok ? (bits_q | sel) : (bits_q & ~sel);
  assign emit     = active && (pos_q == PosW'(MaskPack - 1) || ctl_i.last);

  assign mask_valid_o = emit;
  assign mask_byte_o  = emit ? bits_upd : '0;

  always_comb begin
    bits_d = bits_q;
    pos_d  = pos_q;
    if (ctl_i.adv && active) begin
      if (emit) begin
        bits_d = '0;
        pos_d  = '0;
      end else begin
        bits_d = bits_upd;
        pos_d  = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      pos_q  <= '0;
    end else begin
      bits_q <= bits_d;
      pos_q  <= pos_d;
    end
  end

endmodule

/* src/int8_quantized_add_requantize.sv */
`timescale 1ns / 1ps
// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tdata: elem_a[7:0], elem_b[15:8]; tlast: last_elem
// m_axis    out  tdata: sum_out[7:0], mask_byte[15:8]; tuser: in_range, mask_byte_valid
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// One beat in and one beat out per cycle while the output is not stalled.
// Stages: input register, product register (two 8x32 multiplies), result register.
// Each stage advances on its own, so bubbles are squeezed out under output stalls.
// Reset empties the pipe, loads the default registers and clears the mask packer.

module int8_quantized_add_requantize import iqar_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,   // elem_a, elem_b
  input  logic            s_axis_tlast,   // last_elem
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // sum_out, mask_byte
  output logic [1:0]      m_axis_tuser,   // in_range, mask_byte_valid
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam logic [31:0] ScaleOne = 32'(64'd1 << FRAC_BITS);

  logic [31:0]      scale_a_q, scale_b_q;
  logic [BiasW-1:0] bias_q;
  logic [1:0]       mode_q;

  prod_beat_t prod;
  rq_res_t    res;
  pack_ctl_t  pctl;
  logic       out_free, out_load;
  logic [7:0] mbyte;
  logic       mvalid;

  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_a_q <= ScaleOne;
      scale_b_q <= ScaleOne;
      bias_q    <= '0;
      mode_q    <= MODE_NONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCALE_A: scale_a_q <= cfg_data_i[31:0];
        CFG_SCALE_B: scale_b_q <= cfg_data_i[31:0];
        CFG_BIAS:    bias_q    <= cfg_data_i[BiasW-1:0];
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        default:     mode_q    <= mode_q;
      endcase
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = prod.valid && out_free;

  iqar_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .elem_a_i     (s_axis_tdata[7:0]),
    .elem_b_i     (s_axis_tdata[15:8]),
    .last_i       (s_axis_tlast),
    .scale_a_i    (scale_a_q),
    .scale_b_i    (scale_b_q),
    .down_ready_i (out_free),
    .prod_o       (prod)
  );

  iqar_requant #(.FRAC_BITS(FRAC_BITS)) u_requant (
    .prod_a_i (prod.prod_a),
    .prod_b_i (prod.prod_b),
    .bias_i   (bias_q),
    .res_o    (res)
  );

  assign pctl.adv  = out_load;
  assign pctl.last = prod.last;
  assign pctl.ok   = res.ok;
  assign pctl.mode = mode_q;

  iqar_mask_pack u_mask (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pctl),
    .mask_byte_o  (mbyte),
    .mask_valid_o (mvalid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= prod.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {mbyte, res.sum};
      out_user_q <= {mvalid, res.ok};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* src/iqar_checker.sv */
`timescale 1ns / 1ps
`include "int8_quantized_add_requantize_macros.svh"

module iqar_checker import iqar_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        out_stall;
  logic        out_clamped;
  logic        out_at_limit;
  logic        out_no_mask;
  logic        out_mask_zero;
  logic [17:0] out_beat;

  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_beat      = {m_axis_tuser, m_axis_tdata};
  assign out_clamped   = m_axis_tvalid && !m_axis_tuser[0];
  assign out_at_limit  = (m_axis_tdata[7:0] == 8'h80) || (m_axis_tdata[7:0] == 8'h7f);
  assign out_no_mask   = m_axis_tvalid && !m_axis_tuser[1];
  assign out_mask_zero = m_axis_tdata[15:8] == 8'h00;

  // hold a stalled beat
  `IQAR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_beat))

  // a clamped sum sits at one of the int8 limits
  `IQAR_ASSERT_IMP(a_clamp_limit, clk_i, rst_ni, out_clamped, out_at_limit)

  // no mask byte, no mask bits
  `IQAR_ASSERT_IMP(a_mask_zero, clk_i, rst_ni, out_no_mask, out_mask_zero)

endmodule

bind int8_quantized_add_requantize iqar_checker u_iqar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
